[rtl/core/tcsl_pkg.sv]
// shared constants, types and helpers of the tone chip serial loader
package tcsl_pkg;

    // shadow file geometry
    localparam int NUM_TONE_REGS = 8;
    localparam int IDX_W = (NUM_TONE_REGS > 1) ? $clog2(NUM_TONE_REGS) : 1;
    localparam logic [7:0] TRIG_ADDR = 8'(NUM_TONE_REGS - 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TONE_REGS - 1);

    // serial load bit fields
    localparam logic [5:0] TONE_MASK = 6'h3f;
    localparam logic [7:0] BIT_CE = 8'h80;
    localparam logic [7:0] BIT_CLK = 8'h40;
    localparam logic [15:0] SERIAL_PORT = 16'h008c;

    // wait times in ticks
    localparam logic [6:0] WAIT_ENABLE = 7'd24;
    localparam logic [6:0] WAIT_SET = 7'd32;
    localparam logic [6:0] WAIT_CLOCK = 7'd48;
    localparam logic [6:0] WAIT_SETTLE = 7'd64;
    localparam logic [6:0] WAIT_LO_LAST = WAIT_CLOCK + WAIT_SETTLE;
    localparam logic [6:0] WAIT_NONE = 7'd0;

    // pass-through host addresses and their bus targets
    localparam logic [7:0] REG_PASS_A = 8'h10;
    localparam logic [7:0] REG_PASS_B = 8'h11;
    localparam logic [7:0] REG_PASS_C = 8'h12;
    localparam logic [7:0] REG_PASS_D = 8'h20;
    localparam logic [7:0] REG_PASS_E = 8'h21;
    localparam logic [15:0] BUS_PASS_A = 16'h0088;
    localparam logic [15:0] BUS_PASS_B = 16'h008a;
    localparam logic [15:0] BUS_PASS_C = 16'h0188;
    localparam logic [15:0] BUS_PASS_D = 16'h018c;
    localparam logic [15:0] BUS_PASS_E = 16'h018e;

    // configuration port
    localparam int PADDR_W = 3;
    localparam logic CFG_SLOT_NUMBER = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ENABLE,
        ST_SET,
        ST_HI,
        ST_LO,
        ST_RELEASE,
        ST_PASS
    } state_t;

    typedef enum logic [2:0] {
        EMIT_ENABLE,
        EMIT_SET,
        EMIT_HI,
        EMIT_LO,
        EMIT_RELEASE,
        EMIT_PASS
    } emit_kind_t;

    typedef struct packed {
        logic       shadow_wr;
        logic       pass_ld;
        logic       emit;
        emit_kind_t kind;
        logic       idx_clr;
        logic       idx_inc;
    } cmd_t;

    typedef struct packed {
        logic is_tone;
        logic is_trig;
        logic is_pass;
        logic idx_last;
        logic out_free;
    } sts_t;

    function automatic logic is_pass_addr(input logic [7:0] a);
        return (a == REG_PASS_A) || (a == REG_PASS_B) || (a == REG_PASS_C) ||
               (a == REG_PASS_D) || (a == REG_PASS_E);
    endfunction

    function automatic logic [15:0] pass_bus_addr(input logic [7:0] a);
        logic [15:0] r;
        r = BUS_PASS_A;
        case (a)
            REG_PASS_A: r = BUS_PASS_A;
            REG_PASS_B: r = BUS_PASS_B;
            REG_PASS_C: r = BUS_PASS_C;
            REG_PASS_D: r = BUS_PASS_D;
            REG_PASS_E: r = BUS_PASS_E;
            default:    r = BUS_PASS_A;
        endcase
        return r;
    endfunction

endpackage

[rtl/core/tone_chip_serial_loader.sv]
// top level of the tone chip serial loader: configuration port and core wiring
//
// tone chip serial loader: each host transaction (reg_addr, write_data) becomes zero or more
// timed bus write transactions on the m_ channel. addresses below NUM_TONE_REGS-1 only
// update the 6-bit shadow file (no result). address NUM_TONE_REGS-1 updates
// its shadow entry and then plays the full serial load: one enable write, three writes
// per shadow entry, one release write, 3*NUM_TONE_REGS+2 results (26 with eight
// entries). the sequencer emits one result per cycle into a single result register while
// m_ready stays high, and holds under back-pressure. a pass-through address first loads
// its bus target and data into a register, then emits one result. the input side
// waits (s_ready low) while a load or pass-through is being emitted, but a finished result
// can sit in the result register while the next transaction is accepted. slot_number
// (APB register 0, byte address 0) is stamped on every result. the shadow file clears at
// reset, no clearing pass is needed.
module tone_chip_serial_loader (
    input  logic                          aclk,
    input  logic                          aresetn,
    // host register write transactions
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [7:0]                    s_reg_addr,
    input  logic [7:0]                    s_write_data,
    // bus write transactions
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [3:0]                    m_slot_out,
    output logic [15:0]                   m_bus_addr,
    output logic [7:0]                    m_bus_data,
    output logic [6:0]                    m_wait_ticks,
    output logic                          m_last,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tcsl_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    logic           cfg_wr;
    logic           cfg_idx;
    logic [3:0]     slot_number_reg;
    logic [3:0]     slot_number_next;
    tcsl_pkg::cmd_t cmd;
    tcsl_pkg::sts_t sts;

    // register index is the word address; only register 0 exists
    assign pready  = 1'b1;
    assign cfg_idx = paddr[2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb begin
        slot_number_next = slot_number_reg;
        if (cfg_wr && cfg_idx == tcsl_pkg::CFG_SLOT_NUMBER) begin
            slot_number_next = pwdata[3:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_number_reg <= 4'd0;
        end else begin
            slot_number_reg <= slot_number_next;
        end
    end

    // reads outside the register list return zero
    assign prdata = (cfg_idx == tcsl_pkg::CFG_SLOT_NUMBER) ? {28'd0, slot_number_reg} : 32'd0;

    // sequencer
    tcsl_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // shadow file, decode and result register
    tcsl_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_reg_addr   (s_reg_addr),
        .s_write_data (s_write_data),
        .slot_number  (slot_number_reg),
        .cmd          (cmd),
        .sts          (sts),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_slot_out   (m_slot_out),
        .m_bus_addr   (m_bus_addr),
        .m_bus_data   (m_bus_data),
        .m_wait_ticks (m_wait_ticks),
        .m_last       (m_last)
    );

endmodule

[rtl/core/tcsl_dp.sv]
// datapath: host address decode, tone shadow file, load index and result register
module tcsl_dp (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [7:0]            s_reg_addr,
    input  logic [7:0]            s_write_data,
    input  logic [3:0]            slot_number,
    input  tcsl_pkg::cmd_t        cmd,
    output tcsl_pkg::sts_t        sts,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [3:0]            m_slot_out,
    output logic [15:0]           m_bus_addr,
    output logic [7:0]            m_bus_data,
    output logic [6:0]            m_wait_ticks,
    output logic                  m_last
);

    logic [5:0]                   shadow_reg [tcsl_pkg::NUM_TONE_REGS];
    logic [tcsl_pkg::IDX_W-1:0]   idx_reg;
    logic [tcsl_pkg::IDX_W-1:0]   idx_next;
    logic [15:0]                  pass_addr_reg;
    logic [7:0]                   pass_data_reg;
    logic                         m_valid_reg;
    logic                         m_valid_next;
    logic [3:0]                   m_slot_reg;
    logic [15:0]                  m_bus_addr_reg;
    logic [7:0]                   m_bus_data_reg;
    logic [6:0]                   m_wait_reg;
    logic                         m_last_reg;
    logic [15:0]                  bus_addr_next;
    logic [7:0]                   bus_data_next;
    logic [6:0]                   wait_next;
    logic                         last_next;
    logic [5:0]                   tone_val;
    logic [tcsl_pkg::IDX_W-1:0]   wr_idx;

    assign wr_idx = s_reg_addr[tcsl_pkg::IDX_W-1:0];
    assign tone_val = shadow_reg[idx_reg];

    assign sts.is_tone  = s_reg_addr < tcsl_pkg::TRIG_ADDR;
    assign sts.is_trig  = s_reg_addr == tcsl_pkg::TRIG_ADDR;
    assign sts.is_pass  = tcsl_pkg::is_pass_addr(s_reg_addr);
    assign sts.idx_last = idx_reg == tcsl_pkg::LAST_IDX;
    assign sts.out_free = !m_valid_reg || m_ready;

    // shadow file, cleared by reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < tcsl_pkg::NUM_TONE_REGS; i++) begin
                shadow_reg[i] <= '0;
            end
        end else if (cmd.shadow_wr) begin
            shadow_reg[wr_idx] <= s_write_data[5:0] & tcsl_pkg::TONE_MASK;
        end
    end

    always_comb begin
        idx_next = idx_reg;
        if (cmd.idx_clr) begin
            idx_next = '0;
        end else if (cmd.idx_inc) begin
            idx_next = idx_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= '0;
        end else begin
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.pass_ld) begin
            pass_addr_reg <= tcsl_pkg::pass_bus_addr(s_reg_addr);
            pass_data_reg <= s_write_data;
        end
    end

    // result word for the current step
    always_comb begin
        bus_addr_next = tcsl_pkg::SERIAL_PORT;
        bus_data_next = tcsl_pkg::BIT_CE;
        wait_next     = tcsl_pkg::WAIT_NONE;
        last_next     = 1'b0;
        unique case (cmd.kind)
            tcsl_pkg::EMIT_ENABLE: begin
                wait_next = tcsl_pkg::WAIT_ENABLE;
            end
            tcsl_pkg::EMIT_SET: begin
                bus_data_next = tcsl_pkg::BIT_CE | {2'b00, tone_val};
                wait_next     = tcsl_pkg::WAIT_SET;
            end
            tcsl_pkg::EMIT_HI: begin
                bus_data_next = tcsl_pkg::BIT_CE | tcsl_pkg::BIT_CLK | {2'b00, tone_val};
                wait_next     = tcsl_pkg::WAIT_CLOCK;
            end
            tcsl_pkg::EMIT_LO: begin
                bus_data_next = tcsl_pkg::BIT_CE | {2'b00, tone_val};
                wait_next     = sts.idx_last ? tcsl_pkg::WAIT_LO_LAST : tcsl_pkg::WAIT_CLOCK;
            end
            tcsl_pkg::EMIT_RELEASE: begin
                bus_data_next = 8'h00;
                last_next     = 1'b1;
            end
            tcsl_pkg::EMIT_PASS: begin
                bus_addr_next = pass_addr_reg;
                bus_data_next = pass_data_reg;
                last_next     = 1'b1;
            end
            default: begin
                bus_data_next = tcsl_pkg::BIT_CE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_slot_reg     <= slot_number;
            m_bus_addr_reg <= bus_addr_next;
            m_bus_data_reg <= bus_data_next;
            m_wait_reg     <= wait_next;
            m_last_reg     <= last_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_slot_out   = m_slot_reg;
    assign m_bus_addr   = m_bus_addr_reg;
    assign m_bus_data   = m_bus_data_reg;
    assign m_wait_ticks = m_wait_reg;
    assign m_last       = m_last_reg;

`ifndef ASSERT_OFF
    a_set_bits: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit && cmd.kind == tcsl_pkg::EMIT_SET) |=>
            (m_bus_data_reg[7] && !m_bus_data_reg[6]))
        else $error("data set word without chip enable or with clock high");
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> (!m_valid_reg || m_ready))
        else $error("result register overwritten before it was taken");
`endif

endmodule

[rtl/core/tcsl_ctrl.sv]
// controller: sequencer for the serial load and the pass-through writes
module tcsl_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  tcsl_pkg::sts_t  sts,
    output tcsl_pkg::cmd_t  cmd
);

    tcsl_pkg::state_t state_reg;
    tcsl_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tcsl_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        s_ready       = 1'b0;
        cmd.shadow_wr = 1'b0;
        cmd.pass_ld   = 1'b0;
        cmd.emit      = 1'b0;
        cmd.kind      = tcsl_pkg::EMIT_PASS;
        cmd.idx_clr   = 1'b0;
        cmd.idx_inc   = 1'b0;
        unique case (state_reg)
            tcsl_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.shadow_wr = sts.is_tone || sts.is_trig;
                    if (sts.is_trig) begin
                        cmd.idx_clr = 1'b1;
                        state_next  = tcsl_pkg::ST_ENABLE;
                    end else if (sts.is_pass) begin
                        cmd.pass_ld = 1'b1;
                        state_next  = tcsl_pkg::ST_PASS;
                    end
                end
            end
            tcsl_pkg::ST_ENABLE: begin
                cmd.kind = tcsl_pkg::EMIT_ENABLE;
                cmd.emit = sts.out_free;
                if (sts.out_free) begin
                    state_next = tcsl_pkg::ST_SET;
                end
            end
            tcsl_pkg::ST_SET: begin
                cmd.kind = tcsl_pkg::EMIT_SET;
                cmd.emit = sts.out_free;
                if (sts.out_free) begin
                    state_next = tcsl_pkg::ST_HI;
                end
            end
            tcsl_pkg::ST_HI: begin
                cmd.kind = tcsl_pkg::EMIT_HI;
                cmd.emit = sts.out_free;
                if (sts.out_free) begin
                    state_next = tcsl_pkg::ST_LO;
                end
            end
            tcsl_pkg::ST_LO: begin
                cmd.kind = tcsl_pkg::EMIT_LO;
                cmd.emit = sts.out_free;
                if (sts.out_free) begin
                    if (sts.idx_last) begin
                        state_next = tcsl_pkg::ST_RELEASE;
                    end else begin
                        cmd.idx_inc = 1'b1;
                        state_next  = tcsl_pkg::ST_SET;
                    end
                end
            end
            tcsl_pkg::ST_RELEASE: begin
                cmd.kind = tcsl_pkg::EMIT_RELEASE;
                cmd.emit = sts.out_free;
                if (sts.out_free) begin
                    state_next = tcsl_pkg::ST_IDLE;
                end
            end
            tcsl_pkg::ST_PASS: begin
                cmd.kind = tcsl_pkg::EMIT_PASS;
                cmd.emit = sts.out_free;
                if (sts.out_free) begin
                    state_next = tcsl_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = tcsl_pkg::ST_IDLE;
            end
        endcase
    end

`ifndef ASSERT_OFF
    a_trig_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && sts.is_trig) |=> (state_reg == tcsl_pkg::ST_ENABLE))
        else $error("trigger write did not start the serial load");
    a_last_lo: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == tcsl_pkg::ST_LO && sts.idx_last && cmd.emit) |=>
            (state_reg == tcsl_pkg::ST_RELEASE))
        else $error("final clock low not followed by release");
`endif

endmodule

[tb/tb_tone_chip_serial_loader.sv]
// self-checking testbench of the tone chip serial loader: directed table, random loads, idling
module tb_tone_chip_serial_loader;

    localparam int TONE_REGS = tcsl_pkg::NUM_TONE_REGS;
    localparam int AW = tcsl_pkg::PADDR_W;
    localparam logic [AW-1:0] SLOT_NUMBER_ADDR = AW'(4 * int'(tcsl_pkg::CFG_SLOT_NUMBER));

    // host address map as seen by the predictor
    localparam logic [7:0] TRIGGER_ADDR = 8'(TONE_REGS - 1);
    localparam int NUM_PASS = 5;
    localparam logic [7:0] PASS_HOST [NUM_PASS] = '{8'h10, 8'h11, 8'h12, 8'h20, 8'h21};
    localparam logic [15:0] PASS_BUS [NUM_PASS] = '{16'h0088, 16'h008a, 16'h0188,
                                                    16'h018c, 16'h018e};

    // serial load encoding
    localparam logic [15:0] LOAD_PORT = 16'h008c;
    localparam logic [7:0] CHIP_ENABLE = 8'h80;
    localparam logic [7:0] WRITE_CLOCK = 8'h40;
    localparam logic [6:0] TICKS_ENABLE = 7'd24;
    localparam logic [6:0] TICKS_SET = 7'd32;
    localparam logic [6:0] TICKS_CLOCK = 7'd48;
    localparam logic [6:0] TICKS_SETTLE = 7'd64;

    // run control
    localparam int IDLE_PERCENT = 29;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES = 30;
    localparam int RUN_LIMIT = 3_000_000;

    typedef struct packed {
        logic [3:0]  slot;
        logic [15:0] bus_addr;
        logic [7:0]  bus_data;
        logic [6:0]  ticks;
        logic        is_last;
    } bus_write_t;

    // how a directed row is checked
    typedef enum logic [1:0] {
        CHK_PREDICT,   // predictor works out the bus writes
        CHK_NONE,      // typed: no bus write at all
        CHK_PASS       // typed: one pass-through bus write
    } check_t;

    typedef struct {
        logic [7:0]  reg_addr;
        logic [7:0]  write_data;
        check_t      check;
        logic [15:0] bus_addr;
    } host_row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic       s_valid = 1'b0;
    wire        s_ready;
    logic [7:0] s_reg_addr = '0;
    logic [7:0] s_write_data = '0;

    wire        m_valid;
    logic       m_ready = 1'b0;
    wire [3:0]  m_slot_out;
    wire [15:0] m_bus_addr;
    wire [7:0]  m_bus_data;
    wire [6:0]  m_wait_ticks;
    wire        m_last;

    logic          psel = 1'b0;
    logic          penable = 1'b0;
    logic          pwrite = 1'b0;
    logic [AW-1:0] paddr = '0;
    logic [31:0]   pwdata = '0;
    wire  [31:0]   prdata;
    wire           pready;

    tone_chip_serial_loader dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_reg_addr   (s_reg_addr),
        .s_write_data (s_write_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_slot_out   (m_slot_out),
        .m_bus_addr   (m_bus_addr),
        .m_bus_data   (m_bus_data),
        .m_wait_ticks (m_wait_ticks),
        .m_last       (m_last),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // predictor state: shadow tone file and slot register as the block should hold them
    logic [5:0] shadow_copy [TONE_REGS];
    logic [3:0] slot_copy;

    // bus writes still owed by the block, oldest first
    bus_write_t pending_bus_writes [$];

    int  mismatch_count = 0;
    bit  no_idle = 1'b0;        // both sides run flat out while set
    bit  hold_off_req = 1'b0;   // asks the receiver for one long stall

    // directed rows: reset state, mask of high data bits, every pass-through, unknown addresses
    host_row_t directed_rows [21] = '{
        '{TRIGGER_ADDR, 8'h00, CHK_PREDICT, 16'h0000},  // load right after reset, file all zero
        '{8'd0,         8'hff, CHK_PREDICT, 16'h0000},  // high bits must be dropped
        '{8'd1,         8'h3f, CHK_PREDICT, 16'h0000},
        '{8'd2,         8'hc0, CHK_PREDICT, 16'h0000},  // only high bits set, stores zero
        '{8'd3,         8'h15, CHK_PREDICT, 16'h0000},
        '{8'd4,         8'h2a, CHK_PREDICT, 16'h0000},
        '{8'd5,         8'h01, CHK_PREDICT, 16'h0000},
        '{8'd6,         8'h20, CHK_PREDICT, 16'h0000},
        '{TRIGGER_ADDR, 8'hff, CHK_PREDICT, 16'h0000},  // trigger also stores its own entry
        '{PASS_HOST[0], 8'h00, CHK_PASS,    16'h0088},
        '{PASS_HOST[1], 8'hff, CHK_PASS,    16'h008a},
        '{PASS_HOST[2], 8'ha5, CHK_PASS,    16'h0188},
        '{PASS_HOST[3], 8'h5a, CHK_PASS,    16'h018c},
        '{PASS_HOST[4], 8'h80, CHK_PASS,    16'h018e},
        '{8'h08,        8'h12, CHK_NONE,    16'h0000},  // just past the trigger
        '{8'h0f,        8'hff, CHK_NONE,    16'h0000},
        '{8'h13,        8'h34, CHK_NONE,    16'h0000},  // just past the pass-through block
        '{8'h1f,        8'h00, CHK_NONE,    16'h0000},
        '{8'h22,        8'h77, CHK_NONE,    16'h0000},
        '{8'hff,        8'hff, CHK_NONE,    16'h0000},  // top of the address range
        '{TRIGGER_ADDR, 8'h00, CHK_PREDICT, 16'h0000}   // ignored rows must not touch the file
    };

    function automatic void expect_write(input logic [15:0] addr, input logic [7:0] data,
                                         input logic [6:0] ticks, input logic is_last);
        pending_bus_writes.push_back('{slot_copy, addr, data, ticks, is_last});
    endfunction

    // updates the shadow copy and queues the bus writes of one host transaction;
    // returns 0 when the block ignores the address
    function automatic bit predict_bus_writes(input logic [7:0] a, input logic [7:0] d);
        logic [7:0] v;
        logic [6:0] lo_ticks;
        if (a < TRIGGER_ADDR) begin
            shadow_copy[a] = d[5:0];
            return 1'b1;
        end
        if (a == TRIGGER_ADDR) begin
            shadow_copy[TONE_REGS-1] = d[5:0];
            expect_write(LOAD_PORT, CHIP_ENABLE, TICKS_ENABLE, 1'b0);
            for (int i = 0; i < TONE_REGS; i++) begin
                v = CHIP_ENABLE | {2'b00, shadow_copy[i]};
                // last clock low also covers the settle time before release
                lo_ticks = (i == TONE_REGS - 1) ? TICKS_CLOCK + TICKS_SETTLE : TICKS_CLOCK;
                expect_write(LOAD_PORT, v, TICKS_SET, 1'b0);
                expect_write(LOAD_PORT, v | WRITE_CLOCK, TICKS_CLOCK, 1'b0);
                expect_write(LOAD_PORT, v, lo_ticks, 1'b0);
            end
            expect_write(LOAD_PORT, 8'h00, 7'd0, 1'b1);
            return 1'b1;
        end
        for (int i = 0; i < NUM_PASS; i++) begin
            if (a == PASS_HOST[i]) begin
                expect_write(PASS_BUS[i], d, 7'd0, 1'b1);
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        mismatch_count++;
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    endtask

    // result checker: every accepted bus write against the oldest expectation
    always @(posedge aclk) begin
        bus_write_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_bus_writes.size() == 0) begin
                report_mismatch("unexpected bus write, addr", m_bus_addr, 16'h0000);
            end else begin
                want = pending_bus_writes.pop_front();
                if (m_slot_out !== want.slot)
                    report_mismatch("slot_out", 16'(m_slot_out), 16'(want.slot));
                if (m_bus_addr !== want.bus_addr)
                    report_mismatch("bus_addr", m_bus_addr, want.bus_addr);
                if (m_bus_data !== want.bus_data)
                    report_mismatch("bus_data", 16'(m_bus_data), 16'(want.bus_data));
                if (m_wait_ticks !== want.ticks)
                    report_mismatch("wait_ticks", 16'(m_wait_ticks), 16'(want.ticks));
                if (m_last !== want.is_last)
                    report_mismatch("last", 16'(m_last), 16'(want.is_last));
            end
        end
    end

    // receiver: random stalls, a flat-out mode, and one long hold-off on request
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_ready = 1'b0;
                // the sender keeps offering meanwhile, so the block backs up and stalls
                repeat (HOLD_OFF_CYCLES) @(negedge aclk);
            end
            m_ready = no_idle || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    // one host transaction; expectations are queued at the edge that accepts it
    task automatic send_host_write(input logic [7:0] a, input logic [7:0] d,
                                   input check_t chk, input logic [15:0] typed_bus,
                                   output bit handled);
        // random gaps before offering, none while running flat out
        while (!no_idle && $urandom_range(99) < IDLE_PERCENT) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_reg_addr = a;
        s_write_data = d;
        s_valid = 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        handled = 1'b1;
        case (chk)
            CHK_PREDICT: handled = predict_bus_writes(a, d);
            CHK_PASS:    expect_write(typed_bus, d, 7'd0, 1'b1);
            CHK_NONE:    handled = 1'b0;
            default:     handled = 1'b0;
        endcase
        @(negedge aclk);
    endtask

    // sender pause: nothing owed, then a settle wait for a transaction that gives no result
    task automatic wait_for_drain();
        s_valid = 1'b0;
        while (pending_bus_writes.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // slot register write over the config port, only with the block idle
    task automatic set_slot_number(input logic [3:0] value);
        wait_for_drain();
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = SLOT_NUMBER_ADDR;
        pwdata = 32'(value);
        @(negedge aclk);
        penable = 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        slot_copy = value;
        @(negedge aclk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    // mostly well-formed loads (tone writes then a trigger), pass-throughs, some noise;
    // ignored addresses do not count toward n
    task automatic run_random(input int n);
        int done;
        int r;
        int k;
        bit handled;
        logic [7:0] a;
        done = 0;
        while (done < n) begin
            r = $urandom_range(99);
            if (r < 55) begin
                k = $urandom_range(1, TONE_REGS - 1);
                repeat (k) begin
                    send_host_write(8'($urandom_range(TONE_REGS - 2)), 8'($urandom),
                                    CHK_PREDICT, 16'h0000, handled);
                end
                send_host_write(TRIGGER_ADDR, 8'($urandom), CHK_PREDICT, 16'h0000, handled);
                done += k + 1;
            end else if (r < 80) begin
                send_host_write(PASS_HOST[$urandom_range(NUM_PASS - 1)], 8'($urandom),
                                CHK_PREDICT, 16'h0000, handled);
                done++;
            end else if (r < 88) begin
                send_host_write(TRIGGER_ADDR, 8'($urandom), CHK_PREDICT, 16'h0000, handled);
                done++;
            end else begin
                a = 8'($urandom);
                send_host_write(a, 8'($urandom), CHK_PREDICT, 16'h0000, handled);
                if (handled) done++;
            end
        end
    endtask

    initial begin
        bit handled;
        for (int i = 0; i < TONE_REGS; i++) shadow_copy[i] = 6'd0;
        slot_copy = 4'd0;

        repeat (10) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // directed table with the slot register at its reset value
        foreach (directed_rows[i]) begin
            send_host_write(directed_rows[i].reg_addr, directed_rows[i].write_data,
                            directed_rows[i].check, directed_rows[i].bus_addr, handled);
        end

        // top slot value, normal idling
        set_slot_number(4'd15);
        run_random(70);

        // a long stretch with no idling on either side
        set_slot_number(4'd9);
        no_idle = 1'b1;
        run_random(60);
        no_idle = 1'b0;

        // receiver holds off while the sender keeps going, then the sender waits it out
        set_slot_number(4'($urandom_range(1, 14)));
        hold_off_req = 1'b1;
        run_random(40);
        wait_for_drain();
        run_random(40);

        // back to the lowest slot value
        set_slot_number(4'd0);
        run_random(40);

        wait_for_drain();
        repeat (TAIL_CYCLES) @(negedge aclk);
        if (mismatch_count == 0) begin
            $display("tb_tone_chip_serial_loader OK");
        end else begin
            $display("tb_tone_chip_serial_loader NOT OK");
        end
        $finish;
    end

    // watchdog, also catches expectations that never arrive
    initial begin
        #(RUN_LIMIT);
        $display("tb_tone_chip_serial_loader NOT OK");
        $finish;
    end

endmodule

[tone_chip_serial_loader.f]
rtl/core/tcsl_pkg.sv
rtl/core/tcsl_dp.sv
rtl/core/tcsl_ctrl.sv
rtl/core/tone_chip_serial_loader.sv
tb/tb_tone_chip_serial_loader.sv
